// ----- hw/rtl/sacl_pkg.sv -----
`timescale 1ns / 1ps

package sacl_pkg;

    // Width of the configuration data and register index.
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED      = 2'd2;

    // Configuration values after reset.
    localparam logic [CFG_W-1:0] OFFSET_BITS_RST    = 4'd6;
    localparam logic [CFG_W-1:0] SET_INDEX_BITS_RST = 4'd4;
    localparam logic [CFG_W-1:0] WAYS_USED_RST      = 4'd8;

    // Width of the clamped way count (holds values up to 31).
    localparam int NW_W = 5;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } sacl_state_t;

endpackage

// ----- hw/rtl/set_assoc_cache_lru_tracker.sv -----
// After an address word is accepted the set's rows are read into registers and the sequencer
// enters its lookup state; the result word is registered when the lookup completes, which
// waits while an earlier result word is still not taken. A new address is taken only once
// the previous lookup has finished; each access reads the set's tag row and metadata row
// from the memories and writes back the metadata row, and the tag row only on a miss.
// Reset: configuration returns to offset 6, set bits 4 and eight ways, counters clear,
// then a clearing pass writes an empty row to each of the 2**MAX_SET_BITS sets (1024 by
// default) while no address is taken; configuration writes are accepted throughout.
`timescale 1ns / 1ps

module set_assoc_cache_lru_tracker
    import sacl_pkg::*;
#(
    parameter int WAYS         = 8,
    parameter int MAX_SET_BITS = 10,
    parameter int ADDR_BITS    = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Address channel
    input  logic                 addr_valid,
    output logic                 addr_ready,
    input  logic [ADDR_BITS-1:0] address,
    // Result channel
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 hit,
    output logic [2:0]           way,
    output logic                 replaced_valid,
    output logic [31:0]          hit_total,
    output logic [31:0]          miss_total
);

    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NSETS  = 1 << MAX_SET_BITS;
    localparam int META_W = WAYS + WAYS * WAY_W;
    localparam int TROW_W = WAYS * ADDR_BITS;

    // Metadata row: valid bits in the low WAYS bits, then the recency list,
    // position 0 holding the least recently used way.
    logic [META_W-1:0]    meta_mem [NSETS];
    logic [TROW_W-1:0]    tag_mem  [NSETS];
    logic [META_W-1:0]    meta_rd_reg;
    logic [TROW_W-1:0]    tag_rd_reg;

    sacl_state_t          state_reg, state_next;
    logic [SET_W-1:0]     clr_cnt_reg;
    logic [CFG_W-1:0]     offset_reg;
    logic [CFG_W-1:0]     set_bits_reg;
    logic [CFG_W-1:0]     ways_reg;
    logic [SET_W-1:0]     set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [31:0]          hit_cnt_reg;
    logic [31:0]          miss_cnt_reg;
    logic                 res_valid_reg;
    logic                 hit_reg;
    logic [2:0]           way_reg;
    logic                 evict_reg;

    logic                 accept;
    logic                 done;
    logic                 meta_we;
    logic [SET_W-1:0]     meta_waddr;
    logic [META_W-1:0]    meta_wdata;
    logic [META_W-1:0]    clr_row;

    logic [NW_W-1:0]      sb;
    logic [SET_W:0]       set_mask;
    logic [ADDR_BITS-1:0] addr_shifted;
    logic [SET_W-1:0]     set_idx;
    logic [5:0]           tag_shift;
    logic [ADDR_BITS-1:0] tag_idx;

    logic [NW_W-1:0]      nw;
    logic [WAYS-1:0]      valid_row;
    logic [WAY_W-1:0]     rec_old [WAYS];
    logic [WAY_W-1:0]     rec_new [WAYS];
    logic                 hit_any;
    logic [WAY_W-1:0]     hit_way;
    logic                 empty_any;
    logic [WAY_W-1:0]     empty_way;
    logic [WAY_W-1:0]     lru_way;
    logic [WAY_W-1:0]     sel_way;
    logic [WAY_W-1:0]     pos;
    logic                 evict;
    logic [WAYS-1:0]      valid_new;
    logic [META_W-1:0]    meta_upd;
    logic [TROW_W-1:0]    tag_upd;
    logic [WAY_W+2:0]     sel_wide;

    // Handshake qualifiers.
    assign accept = addr_valid && addr_ready;
    assign done   = (state_reg == ST_LOOK) && (!res_valid_reg || res_ready);

    // Split the address into set index and tag.
    always_comb
    begin
        sb = (NW_W'(set_bits_reg) > NW_W'(MAX_SET_BITS)) ? NW_W'(MAX_SET_BITS)
                                                         : NW_W'(set_bits_reg);
        set_mask     = ((SET_W+1)'(1) << sb) - (SET_W+1)'(1);
        addr_shifted = address >> offset_reg;
        set_idx      = addr_shifted[SET_W-1:0] & set_mask[SET_W-1:0];
        tag_shift    = 6'(offset_reg) + 6'(sb);
        tag_idx      = address >> tag_shift;
    end

    // Clamp the number of ways in use to the range one to WAYS.
    always_comb
    begin
        if (ways_reg == '0)
            nw = NW_W'(1);
        else if (NW_W'(ways_reg) > NW_W'(WAYS))
            nw = NW_W'(WAYS);
        else
            nw = NW_W'(ways_reg);
    end

    // Lookup, victim choice and recency update on the row read when the address was accepted.
    always_comb
    begin
        int j;
        valid_row = meta_rd_reg[WAYS-1:0];
        for (int i = 0; i < WAYS; i++)
            rec_old[i] = meta_rd_reg[WAYS + i*WAY_W +: WAY_W];

        // Lowest-numbered valid way in use whose tag matches.
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (NW_W'(w) < nw && valid_row[w]
                && tag_rd_reg[w*ADDR_BITS +: ADDR_BITS] == tag_reg)
            begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end

        // Lowest-numbered empty way in use.
        empty_any = 1'b0;
        empty_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (NW_W'(w) < nw && !valid_row[w])
            begin
                empty_any = 1'b1;
                empty_way = WAY_W'(w);
            end
        end

        // Least recent way among those in use.
        lru_way = '0;
        for (int p = WAYS - 1; p >= 0; p--)
        begin
            if (NW_W'(rec_old[p]) < nw)
                lru_way = rec_old[p];
        end

        evict   = !hit_any && !empty_any;
        sel_way = hit_any ? hit_way : (empty_any ? empty_way : lru_way);

        // Move the chosen way to the most recent end of the list.
        pos = '0;
        for (int p = 0; p < WAYS; p++)
        begin
            if (rec_old[p] == sel_way)
                pos = WAY_W'(p);
        end
        for (int i = 0; i < WAYS; i++)
        begin
            j = (i + 1 < WAYS) ? i + 1 : i;
            if (i < int'(pos))
                rec_new[i] = rec_old[i];
            else if (i < WAYS - 1)
                rec_new[i] = rec_old[j];
            else
                rec_new[i] = sel_way;
        end

        valid_new          = valid_row;
        valid_new[sel_way] = 1'b1;
        meta_upd[WAYS-1:0] = valid_new;
        for (int i = 0; i < WAYS; i++)
            meta_upd[WAYS + i*WAY_W +: WAY_W] = rec_new[i];

        tag_upd = tag_rd_reg;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(w) == sel_way)
                tag_upd[w*ADDR_BITS +: ADDR_BITS] = tag_reg;
        end

        sel_wide = (WAY_W+3)'(sel_way);
    end

    // Empty set after reset: nothing valid, ways in ascending recency.
    always_comb
    begin
        clr_row[WAYS-1:0] = '0;
        for (int i = 0; i < WAYS; i++)
            clr_row[WAYS + i*WAY_W +: WAY_W] = WAY_W'(i);
    end

    // Sequencer: next state and memory write controls.
    always_comb
    begin
        state_next = state_reg;
        meta_we    = 1'b0;
        meta_waddr = set_reg;
        meta_wdata = meta_upd;
        unique case (state_reg)
            ST_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_cnt_reg;
                meta_wdata = clr_row;
                if (clr_cnt_reg == SET_W'(NSETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                if (done)
                begin
                    meta_we    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign addr_ready = (state_reg == ST_IDLE);

    // State register and clearing-pass counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
        end
    end

    // Metadata memory: one row per set.
    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_waddr] <= meta_wdata;
        if (accept)
            meta_rd_reg <= meta_mem[set_idx];
    end

    // Tag memory: one row per set; only a miss writes a new tag.
    always_ff @(posedge clk)
    begin
        if (done && !hit_any)
            tag_mem[set_reg] <= tag_upd;
        if (accept)
            tag_rd_reg <= tag_mem[set_idx];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= OFFSET_BITS_RST;
            set_bits_reg <= SET_INDEX_BITS_RST;
            ways_reg     <= WAYS_USED_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS:    offset_reg   <= cfg_data;
                CFG_SET_INDEX_BITS: set_bits_reg <= cfg_data;
                CFG_WAYS_USED:      ways_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Hold the split address of the word in flight.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= set_idx;
            tag_reg <= tag_idx;
        end
    end

    // Saturating hit and miss counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
        end
        else if (done)
        begin
            if (hit_any && hit_cnt_reg != '1)
                hit_cnt_reg <= hit_cnt_reg + 32'd1;
            if (!hit_any && miss_cnt_reg != '1)
                miss_cnt_reg <= miss_cnt_reg + 32'd1;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (done)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            hit_reg   <= hit_any;
            way_reg   <= sel_wide[2:0];
            evict_reg <= evict;
        end
    end

    assign res_valid      = res_valid_reg;
    assign hit            = hit_reg;
    assign way            = way_reg;
    assign replaced_valid = evict_reg;
    assign hit_total      = hit_cnt_reg;
    assign miss_total     = miss_cnt_reg;

    // A result word is on offer after every accepted address.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 res_valid)
        else $error("result word missing two cycles after an accepted address");

    // One access moves at most one of the two counters.
    a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> !(hit_cnt_reg != $past(hit_cnt_reg)
                   && miss_cnt_reg != $past(miss_cnt_reg)))
        else $error("hit and miss counters changed together");

    // A hit never reports an eviction.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && hit |-> !replaced_valid)
        else $error("eviction flagged on a hit");

    // No address is taken while the clearing pass runs.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |=> !$past(accept))
        else $error("address accepted during the clearing pass");

endmodule
